/* sv/schc_pkg.sv */
package schc_pkg;

  // Widths of the step counter and of the position register.
  localparam int unsigned PULSE_COUNT_BITS = 24;
  localparam int unsigned POSITION_BITS    = 32;

  // Widths of the ports, fixed by the interface.
  localparam int unsigned MOVE_PULSES_W    = 24;
  localparam int unsigned MAX_POSITION_W   = 23;
  localparam int unsigned REPORT_POS_W     = 32;

  // Reset value of the upper soft limit.
  localparam logic [MAX_POSITION_W-1:0] MAX_POSITION_RESET = '1;

  // Width used to compare the position against the upper soft limit.
  localparam int unsigned LIMIT_CMP_W = (POSITION_BITS > MAX_POSITION_W) ?
                                        POSITION_BITS + 1 : MAX_POSITION_W + 1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_HOME = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_e;

  // Carriage state carried from one word to the next.
  typedef struct packed {
    logic [PULSE_COUNT_BITS-1:0] pulses_left;
    logic [POSITION_BITS-1:0]    position;
    dir_e                        travel_dir;
    logic                        homed;
    logic                        led;
    logic                        dir_pin;
  } state_t;

  // One incoming word.
  typedef struct packed {
    op_e                      operation;
    logic [MOVE_PULSES_W-1:0] move_pulses;
    logic                     move_forward;
    logic                     endstop;
  } item_t;

  // One result word.
  typedef struct packed {
    logic                    step_pulse;
    logic                    direction_level;
    logic [REPORT_POS_W-1:0] carriage_position;
    logic                    position_reported;
    logic                    moving;
    logic                    is_homed;
    logic                    led_level;
  } result_t;

endpackage

/* sv/schc_step.sv */
// Next-state and result logic for one word: command decode, soft limits,
// one step of the position counter and the homing reset at the endstop.
module schc_step (
  input  schc_pkg::state_t                           state_i,
  input  schc_pkg::item_t                            item_i,
  input  logic [schc_pkg::MAX_POSITION_W-1:0]        max_position_i,
  output schc_pkg::state_t                           state_o,
  output schc_pkg::result_t                          result_o
);

  always_comb begin
    schc_pkg::state_t nx;
    logic             stepped;
    logic             reported;
    logic             pos_neg;
    logic             at_low;
    logic             at_high;

    nx       = state_i;
    stepped  = 1'b0;
    reported = 1'b0;

    // Soft limit flags taken from the position before this word.
    pos_neg = state_i.position[schc_pkg::POSITION_BITS-1];
    at_low  = pos_neg || (state_i.position == '0);
    at_high = !pos_neg &&
              (schc_pkg::LIMIT_CMP_W'(state_i.position) >=
               schc_pkg::LIMIT_CMP_W'(max_position_i));

    case (item_i.operation)
      schc_pkg::OP_MOVE: begin
        nx.travel_dir  = item_i.move_forward ? schc_pkg::DIR_FWD : schc_pkg::DIR_BACK;
        nx.pulses_left = schc_pkg::PULSE_COUNT_BITS'(item_i.move_pulses);
        nx.dir_pin     = item_i.move_forward;
      end
      schc_pkg::OP_HOME: begin
        nx.homed       = 1'b0;
        nx.travel_dir  = schc_pkg::DIR_BACK;
        nx.pulses_left = schc_pkg::PULSE_COUNT_BITS'(1);
        nx.dir_pin     = 1'b0;
      end
      schc_pkg::OP_STOP: begin
        nx.pulses_left = '0;
        nx.travel_dir  = schc_pkg::DIR_IDLE;
      end
      default: begin
        if (state_i.travel_dir != schc_pkg::DIR_IDLE) begin
          // Once homed, the soft limits cancel the remaining steps.
          if (state_i.homed) begin
            if (at_low && state_i.travel_dir == schc_pkg::DIR_BACK) begin
              nx.pulses_left = '0;
            end
            if (at_high && state_i.travel_dir == schc_pkg::DIR_FWD) begin
              nx.pulses_left = '0;
            end
          end
          // Issue one step; the count only runs down once homed.
          if (nx.pulses_left != '0) begin
            if (state_i.homed) begin
              nx.pulses_left = nx.pulses_left - schc_pkg::PULSE_COUNT_BITS'(1);
            end
            if (state_i.travel_dir == schc_pkg::DIR_FWD) begin
              nx.position = state_i.position + schc_pkg::POSITION_BITS'(1);
            end else begin
              nx.position = state_i.position - schc_pkg::POSITION_BITS'(1);
            end
            stepped  = 1'b1;
            reported = 1'b1;
          end
          nx.led = item_i.endstop;
          // First endstop hit while unhomed references the carriage.
          if (item_i.endstop && !state_i.homed) begin
            nx.homed = 1'b1;
            if (nx.position != '0) begin
              reported = 1'b1;
            end
            nx.position    = '0;
            nx.pulses_left = '0;
            nx.travel_dir  = schc_pkg::DIR_IDLE;
          end
        end
      end
    endcase

    state_o                    = nx;
    result_o.step_pulse        = stepped;
    result_o.direction_level   = nx.dir_pin;
    result_o.carriage_position =
      schc_pkg::REPORT_POS_W'(signed'(nx.position));
    result_o.position_reported = reported;
    result_o.moving            = (nx.pulses_left != '0);
    result_o.is_homed          = nx.homed;
    result_o.led_level         = nx.led;
  end

endmodule

/* sv/stepper_carriage_homing_controller_top.sv */
// A word accepted into the input register passes through the step logic into the output register.
// Throughput: one word per cycle while the output is not stalled; the carriage state is updated as each word advances.
// An input register and an output register part the two channels.
// Reset clears the carriage state, the valid flags and sets the upper soft limit to
// its maximum; no clearing pass is needed.
module stepper_carriage_homing_controller_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [schc_pkg::MAX_POSITION_W-1:0]   cfg_max_position_i,
  // Input channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            operation_i,
  input  logic [schc_pkg::MOVE_PULSES_W-1:0]    move_pulses_i,
  input  logic                                  move_forward_i,
  input  logic                                  endstop_i,
  // Output channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  step_pulse_o,
  output logic                                  direction_level_o,
  output logic signed [schc_pkg::REPORT_POS_W-1:0] carriage_position_o,
  output logic                                  position_reported_o,
  output logic                                  moving_o,
  output logic                                  is_homed_o,
  output logic                                  led_level_o
);

  logic [schc_pkg::MAX_POSITION_W-1:0] max_position_q;
  logic                                in_valid_q, in_valid_d;
  schc_pkg::item_t                     item_q;
  logic                                out_valid_q, out_valid_d;
  schc_pkg::result_t                   result_q, result_d;
  schc_pkg::state_t                    state_q, state_d;
  logic                                in_accept;
  logic                                advance;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_position_q <= schc_pkg::MAX_POSITION_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_position_q <= cfg_max_position_i;
    end
  end

  // A word moves from the input register to the output register when the
  // output register is empty or its word is being taken.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.operation    <= schc_pkg::op_e'(operation_i);
      item_q.move_pulses  <= move_pulses_i;
      item_q.move_forward <= move_forward_i;
      item_q.endstop      <= endstop_i;
    end
  end

  // Step logic for the word in the input register.
  schc_step u_step (
    .state_i        (state_q),
    .item_i         (item_q),
    .max_position_i (max_position_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // Carriage state, updated as the word advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pulses_left <= '0;
      state_q.position    <= '0;
      state_q.travel_dir  <= schc_pkg::DIR_IDLE;
      state_q.homed       <= 1'b0;
      state_q.led         <= 1'b0;
      state_q.dir_pin     <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign step_pulse_o        = result_q.step_pulse;
  assign direction_level_o   = result_q.direction_level;
  assign carriage_position_o = signed'(result_q.carriage_position);
  assign position_reported_o = result_q.position_reported;
  assign moving_o            = result_q.moving;
  assign is_homed_o          = result_q.is_homed;
  assign led_level_o         = result_q.led_level;

endmodule

/* dv/stepper_carriage_homing_controller_top_tb.sv */
`timescale 1ns / 1ps

module stepper_carriage_homing_controller_top_tb;

  // Clock, reset and the signals that drive the block.
  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid;
  logic [schc_pkg::MAX_POSITION_W-1:0] cfg_max_position;
  logic in_valid;
  logic [1:0] operation;
  logic [schc_pkg::MOVE_PULSES_W-1:0] move_pulses;
  logic move_forward;
  logic endstop;
  logic out_stall;

  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  logic step_pulse_o;
  logic direction_level_o;
  logic signed [schc_pkg::REPORT_POS_W-1:0] carriage_position_o;
  logic position_reported_o;
  logic moving_o;
  logic is_homed_o;
  logic led_level_o;

  stepper_carriage_homing_controller_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_max_position_i  (cfg_max_position),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation),
    .move_pulses_i       (move_pulses),
    .move_forward_i      (move_forward),
    .endstop_i           (endstop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .step_pulse_o        (step_pulse_o),
    .direction_level_o   (direction_level_o),
    .carriage_position_o (carriage_position_o),
    .position_reported_o (position_reported_o),
    .moving_o            (moving_o),
    .is_homed_o          (is_homed_o),
    .led_level_o         (led_level_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Carriage state as the testbench expects it to be.
  logic [schc_pkg::PULSE_COUNT_BITS-1:0] car_pulses;
  logic [schc_pkg::POSITION_BITS-1:0]    car_position;
  schc_pkg::dir_e                        car_dir;
  logic                                  car_homed;
  logic                                  car_led;
  logic                                  car_dir_pin;
  logic [schc_pkg::MAX_POSITION_W-1:0]   car_limit;

  schc_pkg::result_t expected_reports[$];
  int      mismatches = 0;
  bit      sender_gaps = 1'b1;
  int      hold_left = 0;
  int      burst_left = 0;
  int      calm_left = 0;

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom % 10;
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic reset_carriage();
    car_pulses  = '0;
    car_position = '0;
    car_dir     = schc_pkg::DIR_IDLE;
    car_homed   = 1'b0;
    car_led     = 1'b0;
    car_dir_pin = 1'b0;
    car_limit   = schc_pkg::MAX_POSITION_RESET;
  endtask

  // Apply one word to the expected carriage state and return its report.
  task automatic advance_carriage(input schc_pkg::item_t w, output schc_pkg::result_t r);
    logic stepped;
    logic reported;
    logic at_low;
    logic at_high;
    stepped  = 1'b0;
    reported = 1'b0;
    case (w.operation)
      schc_pkg::OP_MOVE: begin
        car_dir     = w.move_forward ? schc_pkg::DIR_FWD : schc_pkg::DIR_BACK;
        car_pulses  = schc_pkg::PULSE_COUNT_BITS'(w.move_pulses);
        car_dir_pin = w.move_forward;
      end
      schc_pkg::OP_HOME: begin
        car_homed   = 1'b0;
        car_dir     = schc_pkg::DIR_BACK;
        car_pulses  = schc_pkg::PULSE_COUNT_BITS'(1);
        car_dir_pin = 1'b0;
      end
      schc_pkg::OP_STOP: begin
        car_pulses = '0;
        car_dir    = schc_pkg::DIR_IDLE;
      end
      default: begin
        if (car_dir != schc_pkg::DIR_IDLE) begin
          // Soft limits only hold once the carriage is referenced.
          if (car_homed) begin
            at_low  = car_position[schc_pkg::POSITION_BITS-1] || car_position == '0;
            at_high = !car_position[schc_pkg::POSITION_BITS-1] &&
                      car_position >= schc_pkg::POSITION_BITS'(car_limit);
            if (at_low && car_dir == schc_pkg::DIR_BACK) car_pulses = '0;
            if (at_high && car_dir == schc_pkg::DIR_FWD) car_pulses = '0;
          end
          if (car_pulses != '0) begin
            if (car_homed) begin
              car_pulses = car_pulses - schc_pkg::PULSE_COUNT_BITS'(1);
            end
            if (car_dir == schc_pkg::DIR_FWD) begin
              car_position = car_position + schc_pkg::POSITION_BITS'(1);
            end else begin
              car_position = car_position - schc_pkg::POSITION_BITS'(1);
            end
            stepped  = 1'b1;
            reported = 1'b1;
          end
          car_led = w.endstop;
          // First endstop hit while unhomed references the carriage.
          if (w.endstop && !car_homed) begin
            car_homed = 1'b1;
            if (car_position != '0) reported = 1'b1;
            car_position = '0;
            car_pulses   = '0;
            car_dir      = schc_pkg::DIR_IDLE;
          end
        end
      end
    endcase
    r.step_pulse        = stepped;
    r.direction_level   = car_dir_pin;
    r.carriage_position = schc_pkg::REPORT_POS_W'(signed'(car_position));
    r.position_reported = reported;
    r.moving            = car_pulses != '0;
    r.is_homed          = car_homed;
    r.led_level         = car_led;
  endtask

  // Offer one word after an optional gap and record its expected report.
  task automatic send_word(input schc_pkg::op_e op,
                           input logic [schc_pkg::MOVE_PULSES_W-1:0] pulses,
                           input logic fwd, input logic es);
    int                gap;
    schc_pkg::item_t   w;
    schc_pkg::result_t r;
    gap = sender_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    move_pulses  <= pulses;
    move_forward <= fwd;
    endstop      <= es;
    do @(posedge clk_i); while (in_stall_o);
    w.operation    = op;
    w.move_pulses  = pulses;
    w.move_forward = fwd;
    w.endstop      = es;
    advance_carriage(w, r);
    expected_reports.push_back(r);
  endtask

  // Stop offering words and wait until every report has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write the upper soft limit while the block is idle.
  task automatic set_limit(input logic [schc_pkg::MAX_POSITION_W-1:0] value);
    wait_drained();
    cfg_valid        <= 1'b1;
    cfg_max_position <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    car_limit = value;
  endtask

  // Random helpers sized to the fields they feed.
  function automatic logic [schc_pkg::MOVE_PULSES_W-1:0] rand_pulses();
    return schc_pkg::MOVE_PULSES_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Idle ticks, zero-pulse moves, unhomed runs, homing and stop.
  task automatic test_command_basics();
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b1);
    send_word(schc_pkg::OP_MOVE, '0, 1'b1, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b1);
    send_word(schc_pkg::OP_MOVE, '1, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b1, 1'b0);
    send_word(schc_pkg::OP_MOVE, 24'd2, 1'b1, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_STOP, '1, 1'b1, 1'b1);
    send_word(schc_pkg::OP_TICK, '1, 1'b1, 1'b0);
    send_word(schc_pkg::OP_HOME, '0, 1'b1, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b1);
  endtask

  // Upper soft limit at several settings of the register, then a move back to zero.
  task automatic test_soft_limits();
    set_limit(23'd1);
    send_word(schc_pkg::OP_MOVE, 24'd3, 1'b1, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b1);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    set_limit(23'd0);
    send_word(schc_pkg::OP_MOVE, 24'd5, 1'b1, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b1, 1'b0);
    set_limit('1);
    send_word(schc_pkg::OP_MOVE, 24'd1, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_STOP, '0, 1'b0, 1'b0);
  endtask

  // Long receiver hold while words keep coming, then a full drain.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_left = 120;
    send_word(schc_pkg::OP_HOME, '0, 1'b0, 1'b0);
    repeat (4) send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b0);
    send_word(schc_pkg::OP_TICK, '0, 1'b0, 1'b1);
    send_word(schc_pkg::OP_MOVE, 24'd20, 1'b1, 1'b0);
    repeat (24) send_word(schc_pkg::OP_TICK, '0, 1'b0, rand_bit());
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  // Random well-formed command sequences with some noise, over several limits.
  task automatic test_random_sequences();
    int sent;
    int kind;
    int ticks;
    int phase;
    logic [schc_pkg::MOVE_PULSES_W-1:0] pulses;
    sent = 0;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limit(schc_pkg::MAX_POSITION_W'($urandom_range(0, 8388607)));
        1: set_limit(23'd0);
        2: set_limit(schc_pkg::MAX_POSITION_W'($urandom_range(1, 30)));
        3: set_limit('1);
        4: set_limit(schc_pkg::MAX_POSITION_W'($urandom_range(1, 8)));
        default: set_limit(schc_pkg::MAX_POSITION_W'($urandom_range(0, 200)));
      endcase
      while (sent < (phase + 1) * 58) begin
        sender_gaps = ($urandom % 5) != 0;
        kind = $urandom % 10;
        if (kind < 3) begin
          // Homing run, once in a while cut short by a stop.
          send_word(schc_pkg::OP_HOME, rand_pulses(), rand_bit(), rand_bit());
          ticks = $urandom_range(0, 5);
          repeat (ticks) send_word(schc_pkg::OP_TICK, rand_pulses(), rand_bit(), 1'b0);
          if ($urandom % 10 == 0) begin
            send_word(schc_pkg::OP_STOP, rand_pulses(), rand_bit(), rand_bit());
            sent++;
          end
          send_word(schc_pkg::OP_TICK, rand_pulses(), rand_bit(), 1'b1);
          sent += ticks + 2;
        end else if (kind < 7) begin
          // Move followed by ticks, endstop seldom set.
          case ($urandom % 5)
            0: pulses = '0;
            4: pulses = rand_pulses();
            default: pulses = schc_pkg::MOVE_PULSES_W'($urandom_range(1, 12));
          endcase
          send_word(schc_pkg::OP_MOVE, pulses, rand_bit(), rand_bit());
          ticks = $urandom_range(1, 14);
          repeat (ticks) send_word(schc_pkg::OP_TICK, rand_pulses(), rand_bit(),
                                   ($urandom % 12) == 0);
          sent += ticks + 1;
        end else if (kind == 7) begin
          send_word(schc_pkg::OP_STOP, rand_pulses(), rand_bit(), rand_bit());
          ticks = $urandom_range(1, 3);
          repeat (ticks) send_word(schc_pkg::OP_TICK, rand_pulses(), rand_bit(),
                                   rand_bit());
          sent += ticks + 1;
        end else begin
          ticks = $urandom_range(1, 4);
          repeat (ticks) send_word(schc_pkg::op_e'($urandom_range(0, 3)), rand_pulses(),
                                   rand_bit(), rand_bit());
          sent += ticks;
        end
      end
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver stalls: forced holds, random bursts and calm stretches.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else begin
      out_stall <= 1'b0;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        case ($urandom % 16)
          0, 1, 2: burst_left = idle_len();
          3: calm_left = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected 0x%08h, got 0x%08h", name, want, got);
    end
  endtask

  // Compare each report word taken from the block with the oldest expectation.
  always @(posedge clk_i) begin : compare_reports
    schc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report word with no expectation, position 0x%08h",
                   carriage_position_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("step_pulse", 32'(want.step_pulse), 32'(step_pulse_o));
        check_field("direction_level", 32'(want.direction_level),
                    32'(direction_level_o));
        check_field("carriage_position", 32'(want.carriage_position),
                    32'(carriage_position_o));
        check_field("position_reported", 32'(want.position_reported),
                    32'(position_reported_o));
        check_field("moving", 32'(want.moving), 32'(moving_o));
        check_field("is_homed", 32'(want.is_homed), 32'(is_homed_o));
        check_field("led_level", 32'(want.led_level), 32'(led_level_o));
      end
    end
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("stepper_carriage_homing_controller_top_tb failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni           = 1'b0;
    cfg_valid        = 1'b0;
    cfg_max_position = '0;
    in_valid         = 1'b0;
    operation        = schc_pkg::OP_TICK;
    move_pulses      = '0;
    move_forward     = 1'b0;
    endstop          = 1'b0;
    out_stall        = 1'b0;
    reset_carriage();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_command_basics();
    test_soft_limits();
    test_backpressure();
    test_random_sequences();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("stepper_carriage_homing_controller_top_tb passed");
    end else begin
      $display("stepper_carriage_homing_controller_top_tb failed");
    end
    $finish;
  end

endmodule

/* stepper_carriage_homing_controller_top.f */
sv/schc_pkg.sv
sv/schc_step.sv
sv/stepper_carriage_homing_controller_top.sv
dv/stepper_carriage_homing_controller_top_tb.sv
